FILE: rtl/amrdp_pkg.sv
// Shared types and constants for the AMR RTP payload depacketizer.
`timescale 1ns / 1ps

package amrdp_pkg;

  // Parse phases
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_TOC    = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;
  localparam logic [1:0] PH_DRAIN  = 2'd3;

  // Packet status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_FT    = 3'd2;
  localparam logic [2:0] ST_TOC_OVF   = 3'd3;
  localparam logic [2:0] ST_LEN_MISM  = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;

  // Configuration register indexes
  localparam logic CFG_HDR_EN = 1'b0;
  localparam logic CFG_OCTET  = 1'b1;

  // Highest valid frame type
  localparam logic [3:0] FT_MAX = 4'd8;

  // Results per input item and result queue sizing
  localparam int MAX_RES    = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int FCNT_W     = 3;

  // Unrolled parse passes per item (worst case needs three: header skip or a TOC
  // entry, a TOC entry that opens the data phase, then the data stop or drain)
  localparam int PASSES = 3;

  // Stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;

  // One result item
  typedef struct packed {
    logic [7:0] data;
    logic       is_toc;
    logic       frame_last;
    logic       packet_end;
    logic [3:0] cmr;
    logic [2:0] status;
  } res_t;

  // Frame data bytes per frame type; types above 8 count as one byte
  function automatic logic [4:0] frame_size(input logic [3:0] ft);
    logic [4:0] sz;
    case (ft)
      4'd0:    sz = 5'd12;
      4'd1:    sz = 5'd13;
      4'd2:    sz = 5'd15;
      4'd3:    sz = 5'd17;
      4'd4:    sz = 5'd19;
      4'd5:    sz = 5'd20;
      4'd6:    sz = 5'd26;
      4'd7:    sz = 5'd31;
      4'd8:    sz = 5'd5;
      default: sz = 5'd1;
    endcase
    return sz;
  endfunction

  // Mask of the w lowest bits of a 16-bit word
  function automatic logic [15:0] low_mask(input logic [4:0] w);
    logic [16:0] m;
    m = (17'd1 << w) - 17'd1;
    return m[15:0];
  endfunction

  // Peek the top w bits of the c valid low bits of the accumulator
  function automatic logic [7:0] peek_bits(input logic [15:0] a, input logic [4:0] c,
                                           input logic [4:0] w);
    logic [15:0] sh;
    sh = (a >> (c - w)) & low_mask(w);
    return sh[7:0];
  endfunction

endpackage

FILE: rtl/amr_rtp_payload_depacketizer.sv
// Top level: AMR-NB RTP payload bytes in, storage-format TOC and frame bytes out.
`timescale 1ns / 1ps

// The first result of a byte is offered from the result queue, after the input register
//   and a parse pass; a byte waits in the input register while the queue lacks room.
// Throughput: one byte per cycle while the 4-entry result queue has room for three
//   results; a byte that yields k results puts k items out, one per output handshake.
// Reset: synchronous, active low; clears parse state and the queue, sets
//   rtp_header_present to 1 and octet_aligned to 0. The TOC store is not cleared.
module amr_rtp_payload_depacketizer #(
  parameter int MAX_TOC_ENTRIES = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // config write port
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic                             cfg_wdata,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [amrdp_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] in_byte
  input  logic                             in_tlast,   // last_byte
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [amrdp_pkg::OUT_DATA_W-1:0] out_tdata,  // [7:0] out_byte, [11:8] cmr_value,
                                                       // [14:12] status, [15] zero
  output logic [amrdp_pkg::OUT_USER_W-1:0] out_tuser,  // [0] is_toc, [1] frame_last
  output logic                             out_tlast   // packet_end
);
  import amrdp_pkg::*;

  localparam int CNT_W = $clog2(MAX_TOC_ENTRIES + 1);
  localparam int IDX_W = (MAX_TOC_ENTRIES > 1) ? $clog2(MAX_TOC_ENTRIES) : 1;
  localparam logic [CNT_W-1:0] TOC_LIM = CNT_W'(MAX_TOC_ENTRIES);

  // Config registers
  logic hdr_en_r, oct_r;

  // Input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Parse state
  logic [5:0]       toc_store_r [MAX_TOC_ENTRIES];
  logic [CNT_W-1:0] toc_cnt_r, fidx_r;
  logic [4:0]       fbl_r;
  logic [15:0]      acc_r;
  logic [3:0]       bit_cnt_r;
  logic [1:0]       phase_r;
  logic [3:0]       cmr_r;
  logic [9:0]       exp_r;
  logic [10:0]      bcnt_r;
  logic [2:0]       err_r;

  // Next-state values from the parse pass
  logic [5:0]       toc_store_nxt [MAX_TOC_ENTRIES];
  logic [CNT_W-1:0] toc_cnt_nxt, fidx_nxt;
  logic [4:0]       fbl_nxt;
  logic [15:0]      acc_nxt;
  logic [4:0]       bit_cnt_nxt;
  logic [1:0]       phase_nxt;
  logic [3:0]       cmr_nxt;
  logic [9:0]       exp_nxt;
  logic [10:0]      bcnt_nxt;
  logic [2:0]       err_nxt;
  res_t             res_nxt [MAX_RES];
  logic [1:0]       nres_nxt;

  // Result queue
  res_t              fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [FCNT_W-1:0] fcnt_r;
  logic [FCNT_W-1:0] fcnt_after_pop;
  logic              pop, fire;
  res_t              head;

  // Handshake control
  assign pop            = out_tvalid && out_tready;
  assign fcnt_after_pop = fcnt_r - FCNT_W'(pop);
  assign fire           = in_vld_r && (fcnt_after_pop <= FCNT_W'(FIFO_DEPTH - MAX_RES));
  assign in_tready      = !in_vld_r || fire;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_en_r <= 1'b1;
      oct_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_HDR_EN: hdr_en_r <= cfg_wdata;
        CFG_OCTET:  oct_r    <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata[7:0];
      in_last_r <= in_tlast;
    end
  end

  // Parse pass: one byte through header, TOC and data phases
  always_comb begin
    logic       run;
    logic       f, q;
    logic [3:0] ft;
    logic [5:0] e;
    logic [4:0] need;
    logic [2:0] st;
    logic [7:0] pk;

    run = 1'b1;
    f   = 1'b0;
    q   = 1'b0;
    ft  = '0;
    e   = '0;
    need = '0;
    st   = ST_OK;
    pk   = '0;
    for (int k = 0; k < MAX_RES; k++) res_nxt[k] = '0;
    nres_nxt = '0;
    for (int k = 0; k < MAX_TOC_ENTRIES; k++) toc_store_nxt[k] = toc_store_r[k];
    toc_cnt_nxt = toc_cnt_r;
    fidx_nxt    = fidx_r;
    fbl_nxt     = fbl_r;
    acc_nxt     = acc_r;
    bit_cnt_nxt = {1'b0, bit_cnt_r};
    phase_nxt   = phase_r;
    cmr_nxt     = cmr_r;
    exp_nxt     = exp_r;
    bcnt_nxt    = bcnt_r;
    err_nxt     = err_r;

    if (bcnt_r == '0 && in_last_r) begin
      // too short: single end result
      res_nxt[0].packet_end = 1'b1;
      res_nxt[0].status     = ST_SHORT;
      nres_nxt    = 2'd1;
      run         = 1'b0;
    end else begin
      if (bcnt_nxt != 11'h7FF) bcnt_nxt = bcnt_nxt + 11'd1;
      if (phase_nxt != PH_DRAIN) begin
        acc_nxt     = {acc_nxt[7:0], in_byte_r};
        bit_cnt_nxt = bit_cnt_nxt + 5'd8;
      end

      for (int it = 0; it < PASSES; it++) begin
        if (run) begin
          case (phase_nxt)
            PH_HEADER: begin
              need = oct_r ? 5'd8 : 5'd4;
              if (!hdr_en_r) begin
                phase_nxt = PH_TOC;
              end else if (bit_cnt_nxt < need) begin
                run = 1'b0;
              end else begin
                pk          = peek_bits(acc_nxt, bit_cnt_nxt, 5'd4);
                cmr_nxt     = pk[3:0];
                bit_cnt_nxt = bit_cnt_nxt - need;  // reserved bits dropped too
                acc_nxt     = acc_nxt & low_mask(bit_cnt_nxt);
                phase_nxt   = PH_TOC;
              end
            end
            PH_TOC: begin
              need = oct_r ? 5'd8 : 5'd6;
              if (bit_cnt_nxt < need) begin
                run = 1'b0;
              end else begin
                pk = peek_bits(acc_nxt, bit_cnt_nxt, 5'd1);
                f  = pk[0];
                pk = peek_bits(acc_nxt, bit_cnt_nxt - 5'd1, 5'd4);
                ft = pk[3:0];
                if (ft > FT_MAX) begin
                  // bad type: consume F and FT, go to data
                  bit_cnt_nxt = bit_cnt_nxt - 5'd5;
                  acc_nxt     = acc_nxt & low_mask(bit_cnt_nxt);
                  err_nxt     = ST_BAD_FT;
                  phase_nxt   = PH_DATA;
                  fidx_nxt    = '0;
                  fbl_nxt     = '0;
                  bcnt_nxt    = 11'((bit_cnt_nxt + 5'd7) >> 3);
                end else begin
                  pk          = peek_bits(acc_nxt, bit_cnt_nxt - 5'd5, 5'd1);
                  q           = pk[0];
                  bit_cnt_nxt = bit_cnt_nxt - need;
                  acc_nxt     = acc_nxt & low_mask(bit_cnt_nxt);
                  if (toc_cnt_nxt >= TOC_LIM) begin
                    err_nxt     = ST_TOC_OVF;
                    phase_nxt   = PH_DRAIN;
                    acc_nxt     = '0;
                    bit_cnt_nxt = '0;
                    run         = 1'b0;
                  end else begin
                    toc_store_nxt[toc_cnt_nxt[IDX_W-1:0]] = {f, ft, q};
                    toc_cnt_nxt = toc_cnt_nxt + CNT_W'(1);
                    exp_nxt     = exp_nxt + 10'(frame_size(ft));
                    if (!f) begin
                      phase_nxt = PH_DATA;
                      fidx_nxt  = '0;
                      fbl_nxt   = '0;
                      bcnt_nxt  = 11'((bit_cnt_nxt + 5'd7) >> 3);
                    end else if (toc_cnt_nxt >= TOC_LIM) begin
                      err_nxt     = ST_TOC_OVF;
                      phase_nxt   = PH_DRAIN;
                      acc_nxt     = '0;
                      bit_cnt_nxt = '0;
                      run         = 1'b0;
                    end
                  end
                end
              end
            end
            PH_DATA: begin
              if (fidx_nxt >= toc_cnt_nxt || fidx_nxt >= TOC_LIM) begin
                // all frames done: ignore the rest
                phase_nxt   = PH_DRAIN;
                acc_nxt     = '0;
                bit_cnt_nxt = '0;
                run         = 1'b0;
              end else if (bit_cnt_nxt < 5'd8 || nres_nxt >= 2'd2) begin
                run = 1'b0;
              end else begin
                if (fbl_nxt == '0) begin
                  e = toc_store_nxt[fidx_nxt[IDX_W-1:0]];
                  if (nres_nxt != '0) begin
                    run = 1'b0;
                  end else begin
                    res_nxt[nres_nxt].data   = {e[5], e[4:1], e[0], 2'b00};
                    res_nxt[nres_nxt].is_toc = 1'b1;
                    nres_nxt = nres_nxt + 2'd1;
                    fbl_nxt  = frame_size(e[4:1]);
                  end
                end
                if (run) begin
                  res_nxt[nres_nxt].data = peek_bits(acc_nxt, bit_cnt_nxt, 5'd8);
                  bit_cnt_nxt = bit_cnt_nxt - 5'd8;
                  acc_nxt     = acc_nxt & low_mask(bit_cnt_nxt);
                  fbl_nxt     = fbl_nxt - 5'd1;
                  res_nxt[nres_nxt].frame_last = (fbl_nxt == '0);
                  nres_nxt = nres_nxt + 2'd1;
                  if (fbl_nxt == '0) fidx_nxt = fidx_nxt + CNT_W'(1);
                end
              end
            end
            default: run = 1'b0;
          endcase
        end
      end

      // packet end status
      if (in_last_r) begin
        if (err_nxt != ST_OK) begin
          st = err_nxt;
        end else if (phase_nxt == PH_HEADER || phase_nxt == PH_TOC ||
                     (phase_nxt == PH_DATA && fidx_nxt < toc_cnt_nxt)) begin
          st = ST_TRUNC;
        end else if (bcnt_nxt != {1'b0, exp_nxt}) begin
          st = ST_LEN_MISM;
        end else begin
          st = ST_OK;
        end
        res_nxt[nres_nxt].packet_end = 1'b1;
        res_nxt[nres_nxt].cmr        = cmr_nxt;
        res_nxt[nres_nxt].status     = st;
        nres_nxt = nres_nxt + 2'd1;
      end
    end

    // back to header state after every packet
    if (in_last_r) begin
      toc_cnt_nxt = '0;
      fidx_nxt    = '0;
      fbl_nxt     = '0;
      acc_nxt     = '0;
      bit_cnt_nxt = '0;
      phase_nxt   = PH_HEADER;
      cmr_nxt     = '0;
      exp_nxt     = '0;
      bcnt_nxt    = '0;
      err_nxt     = ST_OK;
    end
  end

  // Parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      toc_cnt_r <= '0;
      fidx_r    <= '0;
      fbl_r     <= '0;
      acc_r     <= '0;
      bit_cnt_r <= '0;
      phase_r   <= PH_HEADER;
      cmr_r     <= '0;
      exp_r     <= '0;
      bcnt_r    <= '0;
      err_r     <= ST_OK;
    end else if (fire) begin
      toc_cnt_r <= toc_cnt_nxt;
      fidx_r    <= fidx_nxt;
      fbl_r     <= fbl_nxt;
      acc_r     <= acc_nxt;
      bit_cnt_r <= bit_cnt_nxt[3:0];
      phase_r   <= phase_nxt;
      cmr_r     <= cmr_nxt;
      exp_r     <= exp_nxt;
      bcnt_r    <= bcnt_nxt;
      err_r     <= err_nxt;
    end
  end

  // TOC store, no reset
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int k = 0; k < MAX_TOC_ENTRIES; k++) toc_store_r[k] <= toc_store_nxt[k];
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
    end else begin
      if (fire) wr_ptr_r <= wr_ptr_r + PTR_W'(nres_nxt);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      fcnt_r <= fcnt_after_pop + (fire ? FCNT_W'(nres_nxt) : '0);
    end
  end

  // Result queue payload
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int k = 0; k < MAX_RES; k++) begin
        if (2'(k) < nres_nxt) fifo_r[PTR_W'(wr_ptr_r + PTR_W'(k))] <= res_nxt[k];
      end
    end
  end

  // Output port
  assign head       = fifo_r[rd_ptr_r];
  assign out_tvalid = (fcnt_r != '0);
  assign out_tdata  = {1'b0, head.status, head.cmr, head.data};
  assign out_tuser  = {head.frame_last, head.is_toc};
  assign out_tlast  = head.packet_end;

endmodule

FILE: rtl/amrdp_checker.sv
// Port-level checks for the AMR RTP payload depacketizer, bound to the top level.
`timescale 1ns / 1ps

module amrdp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [amrdp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [amrdp_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                             out_tlast
);
  import amrdp_pkg::*;

  // End item carries no byte and no TOC or frame flags
  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[7:0] == 8'd0 && out_tuser == '0)
    else $error("end item carries data or flags");

  // Status and CMR only on the end item
  a_status_only_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[15:8] == 8'd0)
    else $error("status or cmr on a non-end item");

  // Status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14:12] <= ST_TRUNC)
    else $error("status code out of range");

  // A TOC item is never the last byte of a frame
  a_toc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("item marked both TOC and frame end");

  // Stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled item changed");

endmodule

bind amr_rtp_payload_depacketizer amrdp_checker u_amrdp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
